@@ sv/whac_pkg.sv @@
// Package for the weighted histogram accumulator core.
// Holds sizing constants, register and action codes, and the moment unit request type.
// No dependencies.
`default_nettype none

package whac_pkg;

    // Number of bins held in the bin store.
    localparam int NUM_BINS = 256;
    localparam int BIN_AW   = $clog2(NUM_BINS);

    // Field widths.
    localparam int VAL_W  = 16;
    localparam int WGT_W  = 16;
    localparam int BW_W   = 48;
    localparam int SUM_W  = 64;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_BIN_ORIGIN  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BIN_WIDTH   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BINS_IN_USE = 2'd2;

    // Request actions.
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Request into the moment unit for one accepted sample.
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] value;
        logic [WGT_W-1:0] weight;
        logic [7:0]       bin;
    } mom_req_t;

endpackage

`default_nettype wire

@@ sv/weighted_histogram_accumulator_core.sv @@
// Top level of the weighted histogram accumulator: control sequencer, configuration registers.
// Depends on whac_pkg, whac_div, whac_bin_ram and whac_moments.
//
//  Channel   Signals                                             Flow control
//  -------   -------------------------------------------------   ------------------------------
//  request   start, action, sample_value, sample_weight,         taken when start && !busy
//            read_bin
//  result    done, accepted, bin_index, bin_weight, totals,      one-cycle strobe on done,
//            max_value, max_bin                                  receiver cannot stall
//  config    cfg_write, cfg_index, cfg_data                      written on any edge with cfg_write
//
// A read request returns its result after the registered bin store read. An add request that
// falls below the origin returns in the next cycle; any other add runs through the 16 steps of
// the one-bit-per-cycle index divider, then, when it lands in range, the two multiplier stages
// and the bin read-modify-write. After reset the block sweeps the bin store to zero, one entry
// per cycle, with busy high. Requests are handled one at a time, so the read-modify-write of a
// bin completes before the next request can touch it.
`default_nettype none

module weighted_histogram_accumulator_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Request channel.
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           action,
    input  wire logic [whac_pkg::VAL_W-1:0]     sample_value,
    input  wire logic [whac_pkg::WGT_W-1:0]     sample_weight,
    input  wire logic [7:0]                     read_bin,
    // Result channel.
    output logic                                done,
    output logic                                accepted,
    output logic [7:0]                          bin_index,
    output logic [whac_pkg::BW_W-1:0]           bin_weight,
    output logic [whac_pkg::BW_W-1:0]           total_weight,
    output logic [whac_pkg::SUM_W-1:0]          weighted_sum,
    output logic [whac_pkg::SUM_W-1:0]          weighted_square_sum,
    output logic [whac_pkg::VAL_W-1:0]          max_value,
    output logic [7:0]                          max_bin,
    // Configuration port.
    input  wire logic                           cfg_write,
    input  wire logic [whac_pkg::CFG_IW-1:0]    cfg_index,
    input  wire logic [whac_pkg::CFG_DW-1:0]    cfg_data
);

    localparam int AW = whac_pkg::BIN_AW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL1,
        S_MUL2
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              clr_addr_reg;
    logic [whac_pkg::VAL_W-1:0] value_reg;
    logic [whac_pkg::WGT_W-1:0] weight_reg;
    logic [AW-1:0]              idx_reg;
    logic [7:0]                 bin8_reg;
    logic                       rd_ok_reg;
    logic                       done_reg;
    logic                       accepted_reg;
    logic [7:0]                 bin_index_reg;
    logic [whac_pkg::BW_W-1:0]  bin_weight_reg;

    // Configuration registers.
    logic [whac_pkg::VAL_W-1:0] bin_origin_reg;
    logic [whac_pkg::VAL_W-1:0] bin_width_reg;
    logic [8:0]                 bins_in_use_reg;

    logic                       take;
    logic                       below_origin;
    logic [whac_pkg::VAL_W-1:0] offset;
    logic [whac_pkg::VAL_W-1:0] width_eff;
    logic [15:0]                num_bins16;
    logic [15:0]                count16;
    logic [15:0]                read_ext;
    logic                       read_ok;
    logic                       in_range;
    logic                       div_start;
    logic                       div_done;
    logic [whac_pkg::VAL_W-1:0] div_quotient;
    logic                       hit;
    logic [whac_pkg::BW_W:0]    bin_sum_wide;
    logic [whac_pkg::BW_W-1:0]  bin_sum;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [whac_pkg::BW_W-1:0]  ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [whac_pkg::BW_W-1:0]  ram_rdata;
    whac_pkg::mom_req_t         mom_req;

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_origin_reg  <= '0;
            bin_width_reg   <= 16'd1;
            bins_in_use_reg <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                whac_pkg::CFG_BIN_ORIGIN:  bin_origin_reg  <= cfg_data;
                whac_pkg::CFG_BIN_WIDTH:   bin_width_reg   <= cfg_data;
                whac_pkg::CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[8:0];
                default:                   ;
            endcase
        end
    end

    // Binning arithmetic. A zero width behaves as a width of one, and the bin count
    // is clipped to the size of the store.
    always_comb
    begin
        busy         = state_reg != S_IDLE;
        take         = start && !busy;
        below_origin = sample_value < bin_origin_reg;
        offset       = sample_value - bin_origin_reg;
        width_eff    = (bin_width_reg == '0) ? 16'd1 : bin_width_reg;
        num_bins16   = 16'(whac_pkg::NUM_BINS);
        count16      = ({7'd0, bins_in_use_reg} < num_bins16) ? {7'd0, bins_in_use_reg}
                                                              : num_bins16;
        read_ext     = {8'd0, read_bin};
        read_ok      = read_ext < num_bins16;
        in_range     = div_quotient < count16;
        div_start    = take && (action == whac_pkg::ACT_ADD) && !below_origin;
        hit          = (state_reg == S_DIV) && div_done && in_range;
    end

    // Saturating bin update from the registered read data.
    always_comb
    begin
        bin_sum_wide = {1'b0, ram_rdata} + (whac_pkg::BW_W + 1)'(weight_reg);
        bin_sum      = bin_sum_wide[whac_pkg::BW_W] ? '1 : bin_sum_wide[whac_pkg::BW_W-1:0];
    end

    // Bin store port steering: the clearing sweep and the update share the write port,
    // read requests and bin hits share the read port.
    always_comb
    begin
        ram_we    = (state_reg == S_CLEAR) || (state_reg == S_MUL2);
        ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : idx_reg;
        ram_wdata = (state_reg == S_CLEAR) ? '0 : bin_sum;
        ram_re    = (take && (action == whac_pkg::ACT_READ)) || hit;
        ram_raddr = (state_reg == S_IDLE) ? read_ext[AW-1:0] : div_quotient[AW-1:0];
    end

    always_comb
    begin
        mom_req.start  = hit;
        mom_req.value  = value_reg;
        mom_req.weight = weight_reg;
        mom_req.bin    = div_quotient[7:0];
    end

    // Sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            value_reg      <= '0;
            weight_reg     <= '0;
            idx_reg        <= '0;
            bin8_reg       <= '0;
            rd_ok_reg      <= 1'b0;
            done_reg       <= 1'b0;
            accepted_reg   <= 1'b0;
            bin_index_reg  <= '0;
            bin_weight_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(whac_pkg::NUM_BINS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (action == whac_pkg::ACT_READ)
                        begin
                            rd_ok_reg <= read_ok;
                            bin8_reg  <= read_bin;
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            value_reg  <= sample_value;
                            weight_reg <= sample_weight;
                            if (below_origin)
                            begin
                                done_reg       <= 1'b1;
                                accepted_reg   <= 1'b0;
                                bin_index_reg  <= '0;
                                bin_weight_reg <= '0;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                    end
                end
                S_READ:
                begin
                    done_reg       <= 1'b1;
                    accepted_reg   <= 1'b0;
                    bin_index_reg  <= bin8_reg;
                    bin_weight_reg <= rd_ok_reg ? ram_rdata : '0;
                    state_reg      <= S_IDLE;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (in_range)
                        begin
                            idx_reg   <= div_quotient[AW-1:0];
                            bin8_reg  <= div_quotient[7:0];
                            state_reg <= S_MUL1;
                        end
                        else
                        begin
                            // Index at or past the bin count: the sample is dropped.
                            done_reg       <= 1'b1;
                            accepted_reg   <= 1'b0;
                            bin_index_reg  <= '0;
                            bin_weight_reg <= '0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    // The moment unit commits its totals on this same edge.
                    done_reg       <= 1'b1;
                    accepted_reg   <= 1'b1;
                    bin_index_reg  <= bin8_reg;
                    bin_weight_reg <= bin_sum;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    whac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset),
        .divisor  (width_eff),
        .done     (div_done),
        .quotient (div_quotient)
    );

    whac_bin_ram #(
        .DEPTH (whac_pkg::NUM_BINS),
        .WIDTH (whac_pkg::BW_W),
        .AW    (AW)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    whac_moments u_moments (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req                 (mom_req),
        .total_weight        (total_weight),
        .weighted_sum        (weighted_sum),
        .weighted_square_sum (weighted_square_sum),
        .max_value           (max_value),
        .max_bin             (max_bin)
    );

    assign done       = done_reg;
    assign accepted   = accepted_reg;
    assign bin_index  = bin_index_reg;
    assign bin_weight = bin_weight_reg;

`ifndef SYNTHESIS
    // A taken request either shows its result at once or keeps the block busy.
    a_take_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request taken but neither busy nor done followed");

    // A single bin never holds more weight than the total over all bins.
    a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> (bin_weight <= total_weight))
        else $error("bin weight exceeds total weight");

    // Each square term is at least its linear term, so the square sum dominates.
    a_square_ge_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (weighted_square_sum >= weighted_sum))
        else $error("weighted square sum below weighted sum");
`endif

endmodule

`default_nettype wire

@@ sv/whac_div.sv @@
// Radix-2 restoring divider for the bin index, one quotient bit per cycle.
// Depends on whac_pkg.
`default_nettype none

module whac_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [whac_pkg::VAL_W-1:0] dividend,
    input  wire logic [whac_pkg::VAL_W-1:0] divisor,
    output logic                           done,
    output logic [whac_pkg::VAL_W-1:0]     quotient
);

    localparam int CW = $clog2(whac_pkg::VAL_W);

    logic                       run_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [whac_pkg::VAL_W-1:0] rem_reg;
    logic [whac_pkg::VAL_W-1:0] dq_reg;
    logic [whac_pkg::VAL_W-1:0] dvs_reg;
    logic [whac_pkg::VAL_W:0]   trial;
    logic                       fits;
    logic [whac_pkg::VAL_W-1:0] rem_next;
    logic [whac_pkg::VAL_W-1:0] dq_next;

    // The dividend shifts out of the top of dq_reg while quotient bits shift in below.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[whac_pkg::VAL_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? whac_pkg::VAL_W'(trial - {1'b0, dvs_reg})
                        : trial[whac_pkg::VAL_W-1:0];
        dq_next  = {dq_reg[whac_pkg::VAL_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dq_reg   <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                rem_reg <= '0;
                dq_reg  <= dividend;
                dvs_reg <= divisor;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                dq_reg  <= dq_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(whac_pkg::VAL_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

@@ sv/whac_bin_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module whac_bin_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/whac_moments.sv @@
// Moment unit: two-stage multiply of weight*value*value and saturating running totals.
// Depends on whac_pkg.
`default_nettype none

module whac_moments (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire whac_pkg::mom_req_t        req,
    output logic [whac_pkg::BW_W-1:0]      total_weight,
    output logic [whac_pkg::SUM_W-1:0]     weighted_sum,
    output logic [whac_pkg::SUM_W-1:0]     weighted_square_sum,
    output logic [whac_pkg::VAL_W-1:0]     max_value,
    output logic [7:0]                     max_bin
);

    localparam int WV_W  = whac_pkg::VAL_W + whac_pkg::WGT_W;
    localparam int WVV_W = WV_W + whac_pkg::VAL_W;

    // Stage one: weight times value.
    logic                       p1_valid_reg;
    logic [whac_pkg::VAL_W-1:0] v1_reg;
    logic [whac_pkg::WGT_W-1:0] w1_reg;
    logic [7:0]                 bin1_reg;
    logic [WV_W-1:0]            wv1_reg;

    // Stage two: that product times value again.
    logic                       p2_valid_reg;
    logic [whac_pkg::VAL_W-1:0] v2_reg;
    logic [whac_pkg::WGT_W-1:0] w2_reg;
    logic [7:0]                 bin2_reg;
    logic [WV_W-1:0]            wv2_reg;
    logic [WVV_W-1:0]           wvv2_reg;

    // Accumulators.
    logic [whac_pkg::BW_W-1:0]  total_reg;
    logic [whac_pkg::SUM_W-1:0] sum_reg;
    logic [whac_pkg::SUM_W-1:0] sq_reg;
    logic [whac_pkg::VAL_W-1:0] max_value_reg;
    logic [7:0]                 max_bin_reg;

    logic [whac_pkg::BW_W:0]    total_wide;
    logic [whac_pkg::SUM_W:0]   sum_wide;
    logic [whac_pkg::SUM_W:0]   sq_wide;
    logic [whac_pkg::BW_W-1:0]  total_next;
    logic [whac_pkg::SUM_W-1:0] sum_next;
    logic [whac_pkg::SUM_W-1:0] sq_next;

    always_comb
    begin
        total_wide = {1'b0, total_reg} + (whac_pkg::BW_W + 1)'(w2_reg);
        sum_wide   = {1'b0, sum_reg} + (whac_pkg::SUM_W + 1)'(wv2_reg);
        sq_wide    = {1'b0, sq_reg} + (whac_pkg::SUM_W + 1)'(wvv2_reg);
        total_next = total_wide[whac_pkg::BW_W] ? '1 : total_wide[whac_pkg::BW_W-1:0];
        sum_next   = sum_wide[whac_pkg::SUM_W] ? '1 : sum_wide[whac_pkg::SUM_W-1:0];
        sq_next    = sq_wide[whac_pkg::SUM_W] ? '1 : sq_wide[whac_pkg::SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            v1_reg        <= '0;
            w1_reg        <= '0;
            bin1_reg      <= '0;
            wv1_reg       <= '0;
            v2_reg        <= '0;
            w2_reg        <= '0;
            bin2_reg      <= '0;
            wv2_reg       <= '0;
            wvv2_reg      <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            max_value_reg <= '0;
            max_bin_reg   <= '0;
        end
        else
        begin
            p1_valid_reg <= req.start;
            if (req.start)
            begin
                v1_reg   <= req.value;
                w1_reg   <= req.weight;
                bin1_reg <= req.bin;
                wv1_reg  <= WV_W'(req.weight) * WV_W'(req.value);
            end

            p2_valid_reg <= p1_valid_reg;
            if (p1_valid_reg)
            begin
                v2_reg   <= v1_reg;
                w2_reg   <= w1_reg;
                bin2_reg <= bin1_reg;
                wv2_reg  <= wv1_reg;
                wvv2_reg <= WVV_W'(wv1_reg) * WVV_W'(v1_reg);
            end

            if (p2_valid_reg)
            begin
                total_reg <= total_next;
                sum_reg   <= sum_next;
                sq_reg    <= sq_next;
                if (v2_reg > max_value_reg)
                begin
                    max_value_reg <= v2_reg;
                    max_bin_reg   <= bin2_reg;
                end
            end
        end
    end

    assign total_weight        = total_reg;
    assign weighted_sum        = sum_reg;
    assign weighted_square_sum = sq_reg;
    assign max_value           = max_value_reg;
    assign max_bin             = max_bin_reg;

endmodule

`default_nettype wire
